// File: rtl/uva_pkg.sv
package uva_pkg;

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ASCII,
    ST_HI,
    ST_LO,
    ST_SEQ
  } step_t;

  typedef enum logic [1:0] {
    BR_WAIT_IN,
    BR_DISPATCH,
    BR_WAIT_OUT,
    BR_RUN
  } br_t;

  typedef enum logic [1:0] {
    OS_ASCII,
    OS_HI,
    OS_LO,
    OS_COPY
  } osel_t;

  typedef struct packed {
    logic  take;
    logic  emit;
    osel_t sel;
    logic  shift;
    logic  spoil;
    br_t   br;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{take: 1'b0, emit: 1'b0, sel: OS_COPY, shift: 1'b0, spoil: 1'b0,
          br: BR_WAIT_IN, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.take   = 1'b1;
        w.br     = BR_WAIT_IN;
        w.target = ST_DECIDE;
      end
      ST_DECIDE: begin
        w.br     = BR_DISPATCH;
        w.target = ST_IDLE;
      end
      ST_ASCII: begin
        w.emit   = 1'b1;
        w.sel    = OS_ASCII;
        w.shift  = 1'b1;
        w.br     = BR_WAIT_OUT;
        w.target = ST_DECIDE;
      end
      ST_HI: begin
        w.emit   = 1'b1;
        w.sel    = OS_HI;
        w.spoil  = 1'b1;
        w.br     = BR_WAIT_OUT;
        w.target = ST_LO;
      end
      ST_LO: begin
        w.emit   = 1'b1;
        w.sel    = OS_LO;
        w.shift  = 1'b1;
        w.br     = BR_WAIT_OUT;
        w.target = ST_DECIDE;
      end
      ST_SEQ: begin
        w.emit   = 1'b1;
        w.sel    = OS_COPY;
        w.shift  = 1'b1;
        w.br     = BR_RUN;
        w.target = ST_DECIDE;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic forbidden(logic [7:0] b, logic [1:0] mode);
    logic hit;
    hit = 1'b0;
    if (mode != 2'd0) begin
      if (b < 8'd32) begin
        hit = 1'b1;
      end else if (mode >= 2'd2) begin
        hit = b inside {8'h3F, 8'h3C, 8'h3E, 8'h22, 8'h7C, 8'h2A, 8'h3A};
      end
    end
    return hit;
  endfunction

endpackage

// File: rtl/uva_in_if.sv
interface uva_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/uva_out_if.sv
interface uva_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       all_valid;

  modport source (output valid, output out_byte, output out_last, output all_valid,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input all_valid,
                  output ready);
endinterface

// File: rtl/utf8_validate_and_repair.sv
// Sanitises a UTF-8 byte string word by word. A small control program steps one control
// word per cycle unless it waits on the source or the sink: it takes an input word, makes
// a decision on the byte at the front of the buffer, and sends each output word once the
// sink takes it. Once the buffer empties, one more decision step finds it empty before
// the next word is taken. A non-ASCII lead is held until four bytes are buffered or the
// string ends, so output may trail input by up to three words. The user must see that
// fix_mode is written through fix_mode_we/fix_mode_wdata only while the block is idle;
// the block itself does not enforce this.
module utf8_validate_and_repair (
  input  logic        clk,
  input  logic        rst,
  input  logic        fix_mode_we,
  input  logic [1:0]  fix_mode_wdata,
  uva_in_if.sink      rx,
  uva_out_if.source   tx
);

  uva_pkg::step_t  step;
  uva_pkg::step_t  step_next;
  uva_pkg::uword_t uw;

  logic [7:0] buf_q [4];
  logic [2:0] cnt;
  logic [2:0] run;
  logic [2:0] seq_len;
  logic       last;
  logic       valid;
  logic [1:0] fix_mode;
  logic       in_fire;
  logic       out_fire;
  logic       forb;
  logic       spoil_now;
  logic       at_end;

  assign uw       = uva_pkg::ucode(step);
  assign rx.ready = uw.take;
  assign tx.valid = uw.emit;
  assign in_fire  = rx.valid & rx.ready;
  assign out_fire = tx.valid & tx.ready;
  assign forb     = uva_pkg::forbidden(buf_q[0], fix_mode);
  assign spoil_now = uw.spoil | ((uw.sel == uva_pkg::OS_ASCII) & forb);
  assign at_end   = (uw.br == uva_pkg::BR_DISPATCH) & (cnt == 3'd0);

  always_comb begin
    seq_len = 3'd0;
    if (cnt >= 3'd2 && buf_q[0][7:5] == 3'b110 && uva_pkg::is_cont(buf_q[1])) begin
      seq_len = 3'd2;
    end else if (cnt >= 3'd3 && buf_q[0][7:4] == 4'b1110 &&
                 uva_pkg::is_cont(buf_q[1]) && uva_pkg::is_cont(buf_q[2])) begin
      seq_len = 3'd3;
    end else if (cnt == 3'd4 && buf_q[0][7:3] == 5'b11110 &&
                 uva_pkg::is_cont(buf_q[1]) && uva_pkg::is_cont(buf_q[2]) &&
                 uva_pkg::is_cont(buf_q[3])) begin
      seq_len = 3'd4;
    end
  end

  always_comb begin
    step_next = step;
    case (uw.br)
      uva_pkg::BR_WAIT_IN: begin
        if (in_fire) step_next = uw.target;
      end
      uva_pkg::BR_DISPATCH: begin
        if (cnt == 3'd0) begin
          step_next = uva_pkg::ST_IDLE;
        end else if (!buf_q[0][7]) begin
          step_next = uva_pkg::ST_ASCII;
        end else if (cnt != 3'd4 && !last) begin
          step_next = uva_pkg::ST_IDLE;
        end else if (seq_len == 3'd0) begin
          step_next = uva_pkg::ST_HI;
        end else begin
          step_next = uva_pkg::ST_SEQ;
        end
      end
      uva_pkg::BR_WAIT_OUT: begin
        if (out_fire) step_next = uw.target;
      end
      uva_pkg::BR_RUN: begin
        if (out_fire && run == 3'd1) step_next = uw.target;
      end
      default: begin
        step_next = uva_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (uw.sel)
      uva_pkg::OS_ASCII: tx.out_byte = forb ? uva_pkg::UNDERSCORE : buf_q[0];
      uva_pkg::OS_HI:    tx.out_byte = {6'b110000, buf_q[0][7:6]};
      uva_pkg::OS_LO:    tx.out_byte = {2'b10, buf_q[0][5:0]};
      default:           tx.out_byte = buf_q[0];
    endcase
    tx.out_last  = last & (cnt == 3'd1) & uw.shift;
    tx.all_valid = tx.out_last & valid & ~spoil_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= uva_pkg::ST_IDLE;
      cnt      <= 3'd0;
      run      <= 3'd0;
      last     <= 1'b0;
      valid    <= 1'b1;
      fix_mode <= 2'd0;
    end else begin
      step <= step_next;
      if (fix_mode_we) fix_mode <= fix_mode_wdata;
      if (in_fire) begin
        cnt  <= cnt + 3'd1;
        last <= rx.in_last;
      end
      if (out_fire && uw.shift) cnt <= cnt - 3'd1;
      if (out_fire && spoil_now) valid <= 1'b0;
      if (uw.br == uva_pkg::BR_DISPATCH) run <= seq_len;
      if (out_fire && uw.br == uva_pkg::BR_RUN) run <= run - 3'd1;
      // close the string: restore the validity flag and clear last
      if (at_end && last) begin
        valid <= 1'b1;
        last  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) buf_q[cnt[1:0]] <= rx.in_byte;
    if (out_fire && uw.shift) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
      buf_q[2] <= buf_q[3];
    end
  end

  a_room_on_take: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> cnt <= 3'd3)
    else $error("input word taken with a full buffer");

  a_run_in_buffer: assert property (@(posedge clk) disable iff (rst)
    step == uva_pkg::ST_SEQ |-> run != 3'd0 && run <= cnt)
    else $error("sequence copy runs past the buffered words");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_fire && tx.out_last |=> cnt == 3'd0 && step == uva_pkg::ST_DECIDE)
    else $error("final word sent with words still buffered");

endmodule

// File: dv/utf8_validate_and_repair_tb.sv
`timescale 1ns / 100ps

module utf8_validate_and_repair_tb;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_CTRL     = 2'd1;
  localparam logic [1:0] MODE_PATH     = 2'd2;
  localparam logic [1:0] MODE_PATH_ALT = 2'd3;
  localparam int SETTLE      = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 100;
  localparam int PHASE_WORDS = 75;
  localparam logic [7:0] SPECIALS [11] = '{8'h00, 8'h1F, 8'h20, 8'h3F, 8'h3C, 8'h3E,
                                           8'h22, 8'h7C, 8'h2A, 8'h3A, 8'h7F};

  typedef logic [7:0] bytes_t [$];

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       ok;
  } out_word_t;

  class utf8_repair_model;
    logic [1:0] mode;
    logic [7:0] held [3];
    int         held_n;
    logic       clean;
    out_word_t  expected_bytes [$];
    int         errors;

    function new();
      mode = MODE_OFF;
      held_n = 0;
      clean = 1'b1;
      errors = 0;
    endfunction

    function bit tail(logic [7:0] b);
      return b[7:6] == 2'b10;
    endfunction

    function bit banned(logic [7:0] b);
      if (mode == MODE_OFF) return 1'b0;
      if (b < 8'd32) return 1'b1;
      if (mode == MODE_CTRL) return 1'b0;
      case (b)
        8'h3F, 8'h3C, 8'h3E, 8'h22, 8'h7C, 8'h2A, 8'h3A: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function int seq_len(logic [7:0] w [4], int n);
      if (n < 2) return 0;
      if (w[0][7:5] == 3'b110 && tail(w[1])) return 2;
      if (n < 3) return 0;
      if (w[0][7:4] == 4'b1110 && tail(w[1]) && tail(w[2])) return 3;
      if (n < 4) return 0;
      if (w[0][7:3] == 5'b11110 && tail(w[1]) && tail(w[2]) && tail(w[3])) return 4;
      return 0;
    endfunction

    function void add(logic [7:0] b);
      out_word_t w;
      w.b = b;
      w.last = 1'b0;
      w.ok = 1'b0;
      expected_bytes.push_back(w);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] win [4];
      logic [7:0] lead;
      int         n;
      int         used;
      int         first;
      out_word_t  w;
      for (int i = 0; i < held_n; i++) win[i] = held[i];
      n = held_n;
      win[n] = b;
      n++;
      first = expected_bytes.size();
      while (n > 0) begin
        lead = win[0];
        if (!lead[7]) begin
          if (banned(lead)) begin
            add(uva_pkg::UNDERSCORE);
            clean = 1'b0;
          end else begin
            add(lead);
          end
          used = 1;
        end else begin
          if (n < 4 && !last) break;
          used = seq_len(win, n);
          if (used == 0) begin
            add({6'b110000, lead[7:6]});
            add({2'b10, lead[5:0]});
            clean = 1'b0;
            used = 1;
          end else begin
            for (int i = 0; i < used; i++) add(win[i]);
          end
        end
        for (int i = used; i < n; i++) win[i - used] = win[i];
        n -= used;
      end
      if (last) begin
        if (expected_bytes.size() > first) begin
          w = expected_bytes.pop_back();
          w.last = 1'b1;
          w.ok = clean;
          expected_bytes.push_back(w);
        end
        held_n = 0;
        clean = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) held[i] = win[i];
        held_n = n;
      end
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic ok);
      out_word_t w;
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: out_byte %h out_last %b all_valid %b", b, last, ok);
        errors++;
        return;
      end
      w = expected_bytes.pop_front();
      if (b !== w.b) begin
        $error("out_byte: expected %h, got %h", w.b, b);
        errors++;
      end
      if (last !== w.last) begin
        $error("out_last: expected %b, got %b", w.last, last);
        errors++;
      end
      if (ok !== w.ok) begin
        $error("all_valid: expected %b, got %b", w.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       fix_mode_we;
  logic [1:0] fix_mode_wdata;
  int         hold_asks = 0;
  int         burst_left = 0;
  int         quiet = 0;

  utf8_repair_model board = new();

  uva_in_if  in_ch ();
  uva_out_if out_ch ();

  utf8_validate_and_repair u_dut (
    .clk            (clk),
    .rst            (rst),
    .fix_mode_we    (fix_mode_we),
    .fix_mode_wdata (fix_mode_wdata),
    .rx             (in_ch),
    .tx             (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: long hold on request, otherwise one of four stall styles picked at random.
  initial begin : receiver
    int hold_left;
    int seen;
    int style;
    int age;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    seen = 0;
    style = 0;
    age = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready) begin
          board.check_byte(out_ch.out_byte, out_ch.out_last, out_ch.all_valid);
        end
        if (seen != hold_asks) begin
          seen = hold_asks;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          age++;
          if (age >= 40) begin
            age = 0;
            style = $urandom_range(0, 3);
          end
          case (style)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ((age % 8) < 5);
          endcase
        end
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic last);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_byte(b, last);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_string(bytes_t s);
    for (int i = 0; i < s.size(); i++) begin
      send_word(s[i], i == s.size() - 1);
      pace();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    fix_mode_we    <= 1'b1;
    fix_mode_wdata <= m;
    @(posedge clk);
    fix_mode_we    <= 1'b0;
    board.mode = m;
  endtask

  function automatic bytes_t random_string();
    bytes_t     s;
    logic [7:0] seq [4];
    int         kind;
    int         len;
    int         cut;
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0: s.push_back(SPECIALS[$urandom_range(0, 10)]);
        1, 2, 3: s.push_back(8'($urandom_range(0, 127)));
        4, 5, 6, 7: begin
          len = (kind == 7) ? $urandom_range(2, 4) : kind - 2;
          case (len)
            2: seq[0] = {3'b110, 5'($urandom)};
            3: seq[0] = {4'b1110, 4'($urandom)};
            default: seq[0] = {5'b11110, 3'($urandom)};
          endcase
          for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
          cut = (kind == 7) ? $urandom_range(1, len - 1) : len;
          for (int i = 0; i < cut; i++) s.push_back(seq[i]);
          if (kind == 7 && $urandom_range(0, 1)) s.push_back(8'($urandom_range(0, 127)));
        end
        8, 9: s.push_back(8'($urandom_range(0, 255)));
        default: begin
          if ($urandom_range(0, 1)) s.push_back(8'($urandom_range(8'hF8, 8'hFF)));
          else s.push_back({2'b10, 6'($urandom)});
        end
      endcase
    end
    return s;
  endfunction

  task automatic run_phase(int words);
    bytes_t s;
    int     n;
    n = 0;
    while (n < words) begin
      s = random_string();
      send_string(s);
      n += s.size();
    end
  endtask

  initial begin
    bytes_t s;
    rst            <= 1'b1;
    fix_mode_we    <= 1'b0;
    fix_mode_wdata <= MODE_OFF;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.in_last  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_mode(MODE_PATH);
    s = {8'h00, 8'h1F, 8'h20, 8'h7F, 8'h3F, 8'h3C, 8'h3E, 8'h22, 8'h7C, 8'h2A, 8'h3A};
    send_string(s);
    s = {8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_string(s);
    s = {8'h80, 8'hC3, 8'h41, 8'hFF};
    send_string(s);
    s = {8'hE2, 8'h82};
    send_string(s);

    set_mode(MODE_OFF);
    run_phase(PHASE_WORDS);
    set_mode(MODE_CTRL);
    hold_asks++;
    run_phase(PHASE_WORDS);
    set_mode(MODE_PATH_ALT);
    run_phase(PHASE_WORDS);
    set_mode(MODE_PATH);
    run_phase(PHASE_WORDS);
    drain();

    if (board.expected_bytes.size() != 0) begin
      $error("%0d expected words never arrived", board.expected_bytes.size());
    end
    if (board.errors == 0 && board.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/uva_pkg.sv
rtl/uva_in_if.sv
rtl/uva_out_if.sv
rtl/utf8_validate_and_repair.sv
dv/utf8_validate_and_repair_tb.sv
